@@ hw/rtl/bisp_pkg.sv @@
`default_nettype none
package bisp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 33;
  localparam int unsigned SECN_W = 7;

  localparam logic [2:0] KIND_ENTRY  = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_FINISH = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [1:0] ERR_TRUNC   = 2'd0;
  localparam logic [1:0] ERR_OVERRUN = 2'd1;
  localparam logic [1:0] ERR_TOOMANY = 2'd2;

  localparam logic [0:0] CFG_START_OFFSET = 1'd0;
  localparam logic [0:0] CFG_IMAGE_LENGTH = 1'd1;

  typedef struct packed {
    logic [2:0]        kind;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] value;
    logic [SECN_W-1:0] sec;
    logic [1:0]        err;
  } rec_t;

  // One queue entry: a first record plus an optional trailing truncation error.
  typedef struct packed {
    rec_t              rec;
    logic              two;
    logic [SECN_W-1:0] sec2;
  } qentry_t;

endpackage
`default_nettype wire

@@ hw/rtl/boot_image_section_parser_top.sv @@
`default_nettype none
// Boot image section parser.
// Input stream: one image byte per item on s_tdata, position 0 first.
// Output stream: one record per item; m_tuser carries the record kind
// (entry, section header, data byte, finished, error), m_tdata carries
// address, value, section number and error code, and m_tlast marks the
// final record caused by one input byte.
// Configuration: cfg_we/cfg_index/cfg_data write start_offset (index 0) and
// image_length (index 1); write them only while the stream is idle, which the block itself does not enforce.
// Throughput: one byte per cycle. Most bytes make zero or one record; the
// byte finishing the entry word or a section's padding can make two, which
// are sent one after the other. The classifier pushes records into a short queue
// (QUEUE_DEPTH entries) and the output side drains it, so s_tready drops
// only while that queue is full because the receiver stalls.
// A record is queued when its byte is accepted and shows on m_tvalid once it reaches the queue head.
// Reset: rst (synchronous) clears the registers, empties the queue and
// returns to skipping bytes before the entry word. After a finish or error
// record, bytes are still taken but ignored until the next reset.
module boot_image_section_parser_top import bisp_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = 64,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,  // [7:0] data_byte
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [79:0]            m_tdata,  // [31:0] target_address, [63:32] record_value,
                                           // [70:64] section_number, [72:71] error_code
  output logic [2:0]             m_tuser,  // [2:0] record_kind
  output logic                   m_tlast   // last_of_run
);

  logic    in_fire, done, push, pop, full, empty;
  qentry_t push_entry, head;
  rec_t    out_rec;

  // Hold the input only when the queue cannot take a record; after done,
  // bytes are dropped and never need queue space.
  assign s_tready = !full || done;
  assign in_fire  = s_tvalid && s_tready;

  bisp_front #(.MAX_SECTIONS(MAX_SECTIONS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .in_byte    (s_tdata),
    .done       (done),
    .push       (push),
    .push_entry (push_entry)
  );

  bisp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  bisp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec),
    .out_last  (m_tlast)
  );

  // Pack fields from the lowest bit up, zero fill to whole bytes.
  assign m_tdata = {7'b0, out_rec.err, out_rec.sec, out_rec.value, out_rec.addr};
  assign m_tuser = out_rec.kind;

endmodule
`default_nettype wire

@@ hw/rtl/bisp_front.sv @@
`default_nettype none
module bisp_front import bisp_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [WORD_W-1:0]   cfg_data,
  input  wire logic                in_fire,
  input  wire logic [7:0]          in_byte,
  output logic                     done,
  output logic                     push,
  output qentry_t                  push_entry
);

  localparam int unsigned SEC_W = $clog2(MAX_SECTIONS + 1);

  localparam logic [2:0] PH_SKIP  = 3'd0;
  localparam logic [2:0] PH_ENTRY = 3'd1;
  localparam logic [2:0] PH_SIZE  = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  logic [WORD_W-1:0] start_offset, image_length;
  logic [2:0]        phase, phase_next;
  logic [POS_W-1:0]  byte_position;
  logic [WORD_W-1:0] word_acc, word_acc_next;
  logic [1:0]        byte_in_word, byte_in_word_next;
  logic [WORD_W-1:0] current_size, current_size_next;
  logic [WORD_W-1:0] current_address, current_address_next;
  logic [WORD_W-1:0] bytes_into_section, bytes_into_section_next;
  logic [SEC_W-1:0]  section_count, section_count_next;

  logic [POS_W:0]    pos_plus4, pos_plus5;
  logic [POS_W+1:0]  size_end;
  logic              short_here, short_next;
  logic [WORD_W-1:0] word;
  logic [WORD_W:0]   padded;
  logic [WORD_W-1:0] bis_inc;
  logic [SECN_W-1:0] sec_cur, sec_prev;
  logic              has_data;
  rec_t              err_rec;

  assign done       = (phase == PH_DONE);
  assign pos_plus4  = {1'b0, byte_position} + (POS_W+1)'(4);
  assign pos_plus5  = {1'b0, byte_position} + (POS_W+1)'(5);
  assign short_here = pos_plus4 > (POS_W+1)'(image_length);
  assign short_next = pos_plus5 > (POS_W+1)'(image_length);
  assign word       = word_acc | ({24'b0, in_byte} << {byte_in_word, 3'b000});
  assign size_end   = {1'b0, pos_plus5} + (POS_W+2)'(word);
  assign padded     = ({1'b0, current_size} + (WORD_W+1)'(3)) & ~(WORD_W+1)'(3);
  assign bis_inc    = bytes_into_section + WORD_W'(1);
  assign has_data   = bytes_into_section < current_size;
  assign sec_cur    = SECN_W'(section_count);
  assign sec_prev   = SECN_W'(section_count - SEC_W'(1));

  always_comb begin
    err_rec = '{kind: KIND_ERROR, addr: '0, value: '0, sec: sec_cur, err: ERR_TRUNC};
  end

  always_comb begin
    phase_next              = phase;
    word_acc_next           = word_acc;
    byte_in_word_next       = byte_in_word;
    current_size_next       = current_size;
    current_address_next    = current_address;
    bytes_into_section_next = bytes_into_section;
    section_count_next      = section_count;
    push                    = 1'b0;
    push_entry.rec          = err_rec;
    push_entry.two          = 1'b0;
    push_entry.sec2         = sec_cur;

    if (in_fire && phase != PH_DONE) begin
      case (phase)
        PH_SKIP: begin
          if (byte_position == POS_W'(start_offset)) begin
            if (short_here) begin
              push       = 1'b1;
              phase_next = PH_DONE;
            end else begin
              word_acc_next     = {24'b0, in_byte};
              byte_in_word_next = 2'd1;
              phase_next        = PH_ENTRY;
            end
          end
        end
        PH_DATA: begin
          bytes_into_section_next = bis_inc;
          if (has_data) begin
            push           = 1'b1;
            push_entry.rec = '{kind: KIND_DATA, addr: current_address + bytes_into_section,
                               value: {24'b0, in_byte}, sec: sec_prev, err: ERR_TRUNC};
          end
          if ({1'b0, bis_inc} >= padded) begin
            if (short_next) begin
              // Trailing truncation error, after the data record if there is one.
              push           = 1'b1;
              push_entry.two = has_data;
              phase_next     = PH_DONE;
            end else begin
              phase_next = PH_SIZE;
            end
          end
        end
        default: begin
          if (byte_in_word != 2'd3) begin
            word_acc_next     = word;
            byte_in_word_next = byte_in_word + 2'd1;
          end else begin
            word_acc_next     = '0;
            byte_in_word_next = 2'd0;
            push              = 1'b1;
            case (phase)
              PH_ENTRY: begin
                push_entry.rec = '{kind: KIND_ENTRY, addr: '0, value: word,
                                   sec: sec_cur, err: ERR_TRUNC};
                push_entry.two = short_next;
                phase_next     = short_next ? PH_DONE : PH_SIZE;
              end
              PH_SIZE: begin
                if (word == '0) begin
                  push_entry.rec = '{kind: KIND_FINISH, addr: '0,
                                     value: WORD_W'(section_count),
                                     sec: sec_cur, err: ERR_TRUNC};
                  phase_next     = PH_DONE;
                end else if (size_end > (POS_W+2)'(image_length)) begin
                  push_entry.rec.err = ERR_OVERRUN;
                  phase_next         = PH_DONE;
                end else if (section_count >= SEC_W'(MAX_SECTIONS)) begin
                  push_entry.rec.err = ERR_TOOMANY;
                  phase_next         = PH_DONE;
                end else begin
                  push               = 1'b0;
                  current_size_next  = word;
                  section_count_next = section_count + SEC_W'(1);
                  phase_next         = PH_ADDR;
                end
              end
              default: begin
                current_address_next    = word;
                bytes_into_section_next = '0;
                push_entry.rec = '{kind: KIND_HEADER, addr: word, value: current_size,
                                   sec: sec_prev, err: ERR_TRUNC};
                phase_next     = PH_DATA;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset       <= '0;
      image_length       <= '0;
      phase              <= PH_SKIP;
      byte_position      <= '0;
      word_acc           <= '0;
      byte_in_word       <= '0;
      current_size       <= '0;
      current_address    <= '0;
      bytes_into_section <= '0;
      section_count      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_OFFSET: start_offset <= cfg_data;
          CFG_IMAGE_LENGTH: image_length <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && phase != PH_DONE) begin
        byte_position <= byte_position + POS_W'(1);
      end
      phase              <= phase_next;
      word_acc           <= word_acc_next;
      byte_in_word       <= byte_in_word_next;
      current_size       <= current_size_next;
      current_address    <= current_address_next;
      bytes_into_section <= bytes_into_section_next;
      section_count      <= section_count_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bisp_queue.sv @@
`default_nettype none
module bisp_queue import bisp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire qentry_t push_entry,
  input  wire logic    pop,
  output logic         full,
  output logic         empty,
  output qentry_t      head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  qentry_t       slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bisp_back.sv @@
`default_nettype none
module bisp_back import bisp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    empty,
  input  wire qentry_t head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output rec_t         out_rec,
  output logic         out_last
);

  // Set while the trailing record of a two-record entry is on the bus.
  logic second;

  assign out_valid = !empty;
  assign out_last  = second || !head.two;
  assign pop       = out_valid && out_ready && out_last;

  always_comb begin
    out_rec = head.rec;
    if (second) begin
      out_rec = '{kind: KIND_ERROR, addr: '0, value: '0, sec: head.sec2, err: ERR_TRUNC};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (out_valid && out_ready) begin
      second <= !out_last;
    end
  end

endmodule
`default_nettype wire
